/* hdl/gkwm_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gkwm_pkg
// shared constants, register codes and record type of the gapped k-mer
// window minimizer
// ----------------------------------------------------------------------------
package gkwm_pkg;

    localparam int DEF_MAX_WINDOW = 64;
    localparam int DEF_MAX_SPAN   = 64;
    localparam int DEF_MAX_BASES  = 32;
    localparam int DEF_INDEX_BITS = 32;

    localparam int CODE_W    = 64;
    localparam int OUT_IDX_W = 32;
    localparam int CFG_AW    = 4;
    localparam int CFG_DW    = 32;

    // register index codes (byte address is 4 * index)
    localparam logic [1:0] REG_KMER_BASES  = 2'd0;
    localparam logic [1:0] REG_K_SPAN      = 2'd1;
    localparam logic [1:0] REG_WINDOW_SPAN = 2'd2;

    localparam logic [5:0] RST_KMER_BASES  = 6'd10;
    localparam logic [6:0] RST_K_SPAN      = 7'd14;
    localparam logic [6:0] RST_WINDOW_SPAN = 7'd24;

    typedef struct packed {
        logic [CODE_W-1:0]    min_code;
        logic [OUT_IDX_W-1:0] min_position;
        logic [OUT_IDX_W-1:0] run_start;
        logic [OUT_IDX_W-1:0] run_end;
        logic                 last_run;
    } run_rec_t;

endpackage

/* hdl/gkwm_sym_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gkwm_sym_if
// symbol channel: one base or gap mark per word
// ----------------------------------------------------------------------------
interface gkwm_sym_if;
    logic       valid;
    logic       ready;
    logic [1:0] base_code;
    logic       is_gap;
    logic       last_symbol;

    modport source (output valid, base_code, is_gap, last_symbol, input ready);
    modport sink   (input valid, base_code, is_gap, last_symbol, output ready);
endinterface

/* hdl/gkwm_run_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gkwm_run_if
// run record channel: one finished minimizer run per word
// ----------------------------------------------------------------------------
interface gkwm_run_if;
    logic                           valid;
    logic                           ready;
    logic [gkwm_pkg::CODE_W-1:0]    min_code;
    logic [gkwm_pkg::OUT_IDX_W-1:0] min_position;
    logic [gkwm_pkg::OUT_IDX_W-1:0] run_start;
    logic [gkwm_pkg::OUT_IDX_W-1:0] run_end;
    logic                           last_run;

    modport source (output valid, min_code, min_position, run_start, run_end, last_run,
                    input ready);
    modport sink   (input valid, min_code, min_position, run_start, run_end, last_run,
                    output ready);
endinterface

/* hdl/gkwm_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gkwm_ram
// generic simple dual port ram, one write and one registered read port
// ----------------------------------------------------------------------------
module gkwm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* hdl/gapped_kmer_window_minimizer_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gapped_kmer_window_minimizer_unit
// rolling gapped k-mer code with a monotone deque in ram, emits one record
// per finished minimizer run
// ----------------------------------------------------------------------------
//
// channel  dir  handshake        word
// -------  ---  ---------------  ------------------------------------------
// sym      in   valid / ready    base_code, is_gap, last_symbol
// run      out  valid / ready    min_code, min_position, run_start, run_end,
//                                last_run
// apb      in   psel / penable   kmer_bases @0x0, k_span @0x4, window_span @0x8
//
// per symbol: accept, then front probes, back probes, a push if the symbol
// enters the deque, a read of the new front and the finish step; a probe that
// finds the deque empty goes straight to the push, and a skipped symbol only
// reads the front and finishes; every probe is a read step and a compare step,
// set by the registered read port of the deque ram
// reset: asynchronous, active low; the deque needs no clearing pass, the fill
// count marks which entries are live
// stalls: two run words are buffered (output register plus one pending word);
// a new symbol is taken while they wait and the finish step holds until both
// are free
//
module gapped_kmer_window_minimizer_unit #(
    parameter int MAX_WINDOW = gkwm_pkg::DEF_MAX_WINDOW,
    parameter int MAX_SPAN   = gkwm_pkg::DEF_MAX_SPAN,
    parameter int MAX_BASES  = gkwm_pkg::DEF_MAX_BASES,
    parameter int INDEX_BITS = gkwm_pkg::DEF_INDEX_BITS
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [gkwm_pkg::CFG_AW-1:0] paddr,
    input  logic [gkwm_pkg::CFG_DW-1:0] pwdata,
    output logic [gkwm_pkg::CFG_DW-1:0] prdata,
    output logic                        pready,
    gkwm_sym_if.sink                    sym,
    gkwm_run_if.source                  run
);

    localparam int AW       = $clog2(MAX_WINDOW);
    localparam int FILL_W   = $clog2(MAX_WINDOW + 1);
    localparam int SPAN_AW  = $clog2(MAX_SPAN);
    localparam int LEAD_CAP = MAX_WINDOW + MAX_SPAN;
    localparam int LEAD_W   = $clog2(LEAD_CAP + 1);
    localparam int CW       = gkwm_pkg::CODE_W;
    localparam int OW       = gkwm_pkg::OUT_IDX_W;
    localparam int ENT_W    = CW + INDEX_BITS;

    // sequencer states
    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_FRD  = 4'd1;  // read deque front for aging
    localparam logic [3:0] S_FCHK = 4'd2;  // age out front
    localparam logic [3:0] S_BRD  = 4'd3;  // read deque back
    localparam logic [3:0] S_BCHK = 4'd4;  // pop larger back entry
    localparam logic [3:0] S_PUSH = 4'd5;  // write new entry
    localparam logic [3:0] S_F2RD = 4'd6;  // read new front
    localparam logic [3:0] S_FIN  = 4'd7;  // run bookkeeping and records

    // configuration registers
    logic [5:0] kmer_bases_reg;
    logic [6:0] k_span_reg;
    logic [6:0] window_span_reg;

    logic cfg_wr;
    assign cfg_wr = psel && penable && pwrite;
    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kmer_bases_reg  <= gkwm_pkg::RST_KMER_BASES;
            k_span_reg      <= gkwm_pkg::RST_K_SPAN;
            window_span_reg <= gkwm_pkg::RST_WINDOW_SPAN;
        end
        else if (cfg_wr)
        begin
            unique case (paddr[3:2])
                gkwm_pkg::REG_KMER_BASES:  kmer_bases_reg  <= pwdata[5:0];
                gkwm_pkg::REG_K_SPAN:      k_span_reg      <= pwdata[6:0];
                gkwm_pkg::REG_WINDOW_SPAN: window_span_reg <= pwdata[6:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[3:2])
            gkwm_pkg::REG_KMER_BASES:  prdata = {26'd0, kmer_bases_reg};
            gkwm_pkg::REG_K_SPAN:      prdata = {25'd0, k_span_reg};
            gkwm_pkg::REG_WINDOW_SPAN: prdata = {25'd0, window_span_reg};
            default:                   prdata = '0;
        endcase
    end

    // clamped settings
    logic [5:0]        nb;
    logic [LEAD_W-1:0] ks;
    logic [LEAD_W-1:0] ws;
    logic [LEAD_W-1:0] lead_len;
    logic [CW-1:0]     code_mask;

    always_comb
    begin
        if (kmer_bases_reg == 6'd0)
            nb = 6'd1;
        else if (kmer_bases_reg > MAX_BASES)
            nb = 6'(MAX_BASES);
        else
            nb = kmer_bases_reg;

        if (k_span_reg == 7'd0)
            ks = LEAD_W'(1);
        else if (k_span_reg > MAX_SPAN)
            ks = LEAD_W'(MAX_SPAN);
        else
            ks = LEAD_W'(k_span_reg);

        if (window_span_reg == 7'd0)
            ws = LEAD_W'(1);
        else if (window_span_reg > MAX_WINDOW)
            ws = LEAD_W'(MAX_WINDOW);
        else
            ws = LEAD_W'(window_span_reg);

        lead_len = (ks > ws) ? ks : ws;

        for (int b = 0; b < CW / 2; b++)
        begin
            code_mask[2*b +: 2] = (b < nb) ? 2'b11 : 2'b00;
        end
    end

    // sequence state
    logic [3:0]            state_reg, state_next;
    logic [CW-1:0]         roll_reg, roll_next;
    logic [MAX_SPAN-1:0]   gap_hist_reg, gap_hist_next;  // bit j: symbol i-1-j
    logic [INDEX_BITS-1:0] index_reg, index_next;
    logic [LEAD_W-1:0]     lead_reg, lead_next;
    logic [AW-1:0]         head_reg, head_next;
    logic [FILL_W-1:0]     fill_reg, fill_next;
    logic [CW-1:0]         cur_min_reg, cur_min_next;
    logic [INDEX_BITS-1:0] cur_pos_reg, cur_pos_next;
    logic [INDEX_BITS-1:0] cur_start_reg, cur_start_next;
    logic [INDEX_BITS-1:0] cur_end_reg, cur_end_next;

    // per-symbol latches
    logic [INDEX_BITS-1:0] i_reg, i_next;
    logic [LEAD_W-1:0]     seen_reg, seen_next;
    logic                  last_reg, last_next;
    logic                  step_reg, step_next;      // full window step
    logic [INDEX_BITS-1:0] push_start_reg, push_start_next;

    // output buffering
    logic                  run_valid_reg, run_valid_next;
    logic                  pend_valid_reg, pend_valid_next;
    gkwm_pkg::run_rec_t    out_rec_reg, out_rec_next;
    gkwm_pkg::run_rec_t    pend_rec_reg, pend_rec_next;

    // deque ram
    logic             ram_we;
    logic [AW-1:0]    ram_waddr;
    logic [ENT_W-1:0] ram_wdata;
    logic [AW-1:0]    ram_raddr;
    logic [ENT_W-1:0] ram_rdata;

    gkwm_ram #(
        .WIDTH (ENT_W),
        .DEPTH (MAX_WINDOW)
    ) u_deque_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    logic [CW-1:0]         rd_code;
    logic [INDEX_BITS-1:0] rd_start;
    assign rd_code  = ram_rdata[ENT_W-1 -: CW];
    assign rd_start = ram_rdata[INDEX_BITS-1:0];

    // ring position of deque entry k
    function automatic logic [AW-1:0] slot_of(input logic [AW-1:0] head,
                                              input logic [FILL_W-1:0] k);
        logic [FILL_W:0] sum;
        sum = (FILL_W + 1)'(head) + (FILL_W + 1)'(k);
        if (sum >= MAX_WINDOW)
            sum = sum - (FILL_W + 1)'(MAX_WINDOW);
        return AW'(sum);
    endfunction

    function automatic logic [AW-1:0] head_inc(input logic [AW-1:0] head);
        return (head == AW'(MAX_WINDOW - 1)) ? '0 : head + AW'(1);
    endfunction

    logic                  accept;
    logic                  out_free;
    logic                  fin_go;
    logic [LEAD_W:0]       seen_p1;
    logic                  back_gap;
    logic [INDEX_BITS-1:0] age;
    logic                  has_front;
    logic                  rec1_v, rec2_v;
    gkwm_pkg::run_rec_t    rec1, rec2;
    logic [CW-1:0]         c_min;
    logic [INDEX_BITS-1:0] c_pos, c_start, c_end;

    assign sym.ready = (state_reg == S_IDLE);
    assign accept    = sym.valid && sym.ready;
    assign out_free  = !run_valid_reg || run.ready;
    assign fin_go    = (state_reg == S_FIN) && out_free && !pend_valid_reg;
    assign seen_p1   = (LEAD_W + 1)'(seen_reg) + (LEAD_W + 1)'(1);
    assign back_gap  = gap_hist_reg[SPAN_AW'(ks - LEAD_W'(1))];
    assign age       = i_reg - rd_start;
    assign has_front = (fill_reg != '0);

    // run bookkeeping of the finish step
    always_comb
    begin
        c_min   = cur_min_reg;
        c_pos   = cur_pos_reg;
        c_start = cur_start_reg;
        c_end   = cur_end_reg;
        rec1_v  = 1'b0;
        rec1    = '0;
        rec2    = '0;

        if (step_reg)
        begin
            if (rd_code == cur_min_reg)
            begin
                c_end = i_reg - INDEX_BITS'(1);
                c_pos = rd_start;
            end
            else
            begin
                // minimum changed: close the running record
                rec1_v       = 1'b1;
                rec1.min_code     = cur_min_reg;
                rec1.min_position = OW'(cur_pos_reg);
                rec1.run_start    = OW'(cur_start_reg);
                rec1.run_end      = OW'(cur_end_reg);
                rec1.last_run     = 1'b0;
                c_min   = rd_code;
                c_start = i_reg - INDEX_BITS'(ws) + INDEX_BITS'(1);
                c_end   = i_reg;
                c_pos   = rd_start;
            end
        end

        // end of warm-up opens the first run
        if (seen_p1 == (LEAD_W + 1)'(lead_len))
        begin
            c_start = '0;
            c_end   = i_reg;
            c_min   = has_front ? rd_code : '0;
            c_pos   = has_front ? rd_start : '0;
        end

        rec2_v = last_reg && (seen_p1 >= (LEAD_W + 1)'(lead_len));
        rec2.min_code     = has_front ? rd_code : c_min;
        rec2.min_position = OW'(has_front ? rd_start : c_pos);
        rec2.run_start    = OW'(c_start);
        rec2.run_end      = OW'(i_reg);
        rec2.last_run     = 1'b1;
    end

    // sequencer
    always_comb
    begin
        state_next      = state_reg;
        roll_next       = roll_reg;
        gap_hist_next   = gap_hist_reg;
        index_next      = index_reg;
        lead_next       = lead_reg;
        head_next       = head_reg;
        fill_next       = fill_reg;
        cur_min_next    = cur_min_reg;
        cur_pos_next    = cur_pos_reg;
        cur_start_next  = cur_start_reg;
        cur_end_next    = cur_end_reg;
        i_next          = i_reg;
        seen_next       = seen_reg;
        last_next       = last_reg;
        step_next       = step_reg;
        push_start_next = push_start_reg;
        run_valid_next  = run_valid_reg;
        pend_valid_next = pend_valid_reg;
        out_rec_next    = out_rec_reg;
        pend_rec_next   = pend_rec_reg;
        ram_we          = 1'b0;
        ram_waddr       = (fill_reg >= FILL_W'(MAX_WINDOW)) ? head_reg
                                                              : slot_of(head_reg, fill_reg);
        ram_wdata       = {roll_reg, push_start_reg};
        ram_raddr       = head_reg;

        // output side drains independently
        if (run_valid_reg && run.ready)
        begin
            if (pend_valid_reg)
            begin
                out_rec_next    = pend_rec_reg;
                pend_valid_next = 1'b0;
            end
            else
            begin
                run_valid_next = 1'b0;
            end
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    i_next    = index_reg;
                    seen_next = lead_reg;
                    last_next = sym.last_symbol;
                    if (!sym.is_gap)
                        roll_next = {roll_reg[CW-3:0], sym.base_code} & code_mask;
                    gap_hist_next = {gap_hist_reg[MAX_SPAN-2:0], sym.is_gap};
                    index_next    = index_reg + INDEX_BITS'(1);
                    if (lead_reg != LEAD_W'(LEAD_CAP))
                        lead_next = lead_reg + LEAD_W'(1);
                    step_next       = 1'b0;
                    push_start_next = index_reg - INDEX_BITS'(ks) + INDEX_BITS'(1);
                    if ((LEAD_W + 1)'(lead_reg) + (LEAD_W + 1)'(1) == (LEAD_W + 1)'(ks))
                    begin
                        // seed entry
                        push_start_next = '0;
                        state_next      = S_BRD;
                    end
                    else if (lead_reg >= ks && lead_reg < ws)
                    begin
                        state_next = S_BRD;
                    end
                    else if (lead_reg >= lead_len && back_gap)
                    begin
                        step_next  = 1'b1;
                        state_next = S_FRD;
                    end
                    else
                    begin
                        state_next = S_F2RD;
                    end
                end
            end

            S_FRD:
            begin
                ram_raddr  = head_reg;
                state_next = has_front ? S_FCHK : S_PUSH;
            end

            S_FCHK:
            begin
                if (age >= INDEX_BITS'(ws))
                begin
                    head_next  = head_inc(head_reg);
                    fill_next  = fill_reg - FILL_W'(1);
                    state_next = S_FRD;
                end
                else
                begin
                    state_next = S_BRD;
                end
            end

            S_BRD:
            begin
                ram_raddr  = slot_of(head_reg, fill_reg - FILL_W'(1));
                state_next = has_front ? S_BCHK : S_PUSH;
            end

            S_BCHK:
            begin
                if (roll_reg < rd_code)
                begin
                    fill_next  = fill_reg - FILL_W'(1);
                    state_next = S_BRD;
                end
                else
                begin
                    state_next = S_PUSH;
                end
            end

            S_PUSH:
            begin
                ram_we = 1'b1;
                // a full ring overwrites its front entry
                if (fill_reg >= FILL_W'(MAX_WINDOW))
                    head_next = head_inc(head_reg);
                else
                    fill_next = fill_reg + FILL_W'(1);
                state_next = S_F2RD;
            end

            S_F2RD:
            begin
                ram_raddr  = head_reg;
                state_next = S_FIN;
            end

            S_FIN:
            begin
                if (fin_go)
                begin
                    if (rec1_v)
                    begin
                        out_rec_next   = rec1;
                        run_valid_next = 1'b1;
                        if (rec2_v)
                        begin
                            pend_rec_next   = rec2;
                            pend_valid_next = 1'b1;
                        end
                    end
                    else if (rec2_v)
                    begin
                        out_rec_next   = rec2;
                        run_valid_next = 1'b1;
                    end

                    if (last_reg)
                    begin
                        // new sequence starts from scratch
                        roll_next      = '0;
                        gap_hist_next  = '0;
                        index_next     = '0;
                        lead_next      = '0;
                        head_next      = '0;
                        fill_next      = '0;
                        cur_min_next   = '0;
                        cur_pos_next   = '0;
                        cur_start_next = '0;
                        cur_end_next   = '0;
                    end
                    else
                    begin
                        cur_min_next   = c_min;
                        cur_pos_next   = c_pos;
                        cur_start_next = c_start;
                        cur_end_next   = c_end;
                    end
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            roll_reg       <= '0;
            gap_hist_reg   <= '0;
            index_reg      <= '0;
            lead_reg       <= '0;
            head_reg       <= '0;
            fill_reg       <= '0;
            cur_min_reg    <= '0;
            cur_pos_reg    <= '0;
            cur_start_reg  <= '0;
            cur_end_reg    <= '0;
            step_reg       <= 1'b0;
            last_reg       <= 1'b0;
            run_valid_reg  <= 1'b0;
            pend_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            roll_reg       <= roll_next;
            gap_hist_reg   <= gap_hist_next;
            index_reg      <= index_next;
            lead_reg       <= lead_next;
            head_reg       <= head_next;
            fill_reg       <= fill_next;
            cur_min_reg    <= cur_min_next;
            cur_pos_reg    <= cur_pos_next;
            cur_start_reg  <= cur_start_next;
            cur_end_reg    <= cur_end_next;
            step_reg       <= step_next;
            last_reg       <= last_next;
            run_valid_reg  <= run_valid_next;
            pend_valid_reg <= pend_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        i_reg          <= i_next;
        seen_reg       <= seen_next;
        push_start_reg <= push_start_next;
        out_rec_reg    <= out_rec_next;
        pend_rec_reg   <= pend_rec_next;
    end

    assign run.valid        = run_valid_reg;
    assign run.min_code     = out_rec_reg.min_code;
    assign run.min_position = out_rec_reg.min_position;
    assign run.run_start    = out_rec_reg.run_start;
    assign run.run_end      = out_rec_reg.run_end;
    assign run.last_run     = out_rec_reg.last_run;

    // checks
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= FILL_W'(MAX_WINDOW))
        else $error("deque fill above capacity");

    a_pend_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        pend_valid_reg |-> run_valid_reg)
        else $error("pending run word without an output word");

    a_push_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_PUSH) |=> (fill_reg != '0))
        else $error("deque empty after push");

    a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (fin_go && last_reg) |=> (fill_reg == '0 && index_reg == '0 && lead_reg == '0))
        else $error("sequence state not cleared after last symbol");

endmodule

/* bench/tb_gapped_kmer_window_minimizer_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_gapped_kmer_window_minimizer_unit
// drives symbol sequences under several register settings, predicts every
// run word with a bit-true model of the rolling code and deque, and compares
// each accepted run word in order with random idling on both channels
// ----------------------------------------------------------------------------
module tb_gapped_kmer_window_minimizer_unit;

    localparam int WIN_DEPTH  = gkwm_pkg::DEF_MAX_WINDOW;
    localparam int SPAN_DEPTH = gkwm_pkg::DEF_MAX_SPAN;
    localparam int LEAD_LIMIT = gkwm_pkg::DEF_MAX_WINDOW + gkwm_pkg::DEF_MAX_SPAN;
    localparam longint CYCLE_LIMIT = 2000000;
    localparam int RAND_BUDGET = 520;

    // predictor of the run words plus the queue of words still owed
    class minimizer_scoreboard;
        logic [5:0] bases_reg;
        logic [6:0] span_reg;
        logic [6:0] window_reg;
        logic [63:0] roll;
        bit gaps [SPAN_DEPTH];
        logic [63:0] dq_code [WIN_DEPTH];
        logic [31:0] dq_start [WIN_DEPTH];
        int fill;
        int head;
        logic [31:0] sym_idx;
        int seen_cnt;
        logic [63:0] run_min;
        logic [31:0] run_pos, run_first, run_last;
        gkwm_pkg::run_rec_t owed [$];
        int errors;

        function new();
            bases_reg = gkwm_pkg::RST_KMER_BASES;
            span_reg = gkwm_pkg::RST_K_SPAN;
            window_reg = gkwm_pkg::RST_WINDOW_SPAN;
            errors = 0;
            clear_seq();
        endfunction

        function void clear_seq();
            roll = 0;
            foreach (gaps[j]) gaps[j] = 0;
            fill = 0;
            head = 0;
            sym_idx = 0;
            seen_cnt = 0;
            run_min = 0;
            run_pos = 0;
            run_first = 0;
            run_last = 0;
        endfunction

        function int at(int k);
            return (head + k) % WIN_DEPTH;
        endfunction

        function void push_entry(logic [63:0] c, logic [31:0] s);
            while (fill > 0 && c < dq_code[at(fill - 1)]) fill--;
            if (fill >= WIN_DEPTH)
            begin
                head = at(1);
                fill--;
            end
            dq_code[at(fill)] = c;
            dq_start[at(fill)] = s;
            fill++;
        endfunction

        function void owe(logic [63:0] c, logic [31:0] p, logic [31:0] s,
                          logic [31:0] e, logic l);
            gkwm_pkg::run_rec_t r;
            r.min_code = c;
            r.min_position = p;
            r.run_start = s;
            r.run_end = e;
            r.last_run = l;
            owed = {owed, r};
        endfunction

        // accepted symbol
        function void note_symbol(logic [1:0] b, logic g, logic l);
            int nb, ks, ws, lead;
            logic [63:0] msk;
            logic [31:0] i;
            int seen;
            bit back_gap;
            nb = bases_reg == 0 ? 1 : (bases_reg > 32 ? 32 : bases_reg);
            ks = span_reg == 0 ? 1 : (span_reg > 64 ? 64 : span_reg);
            ws = window_reg == 0 ? 1 : (window_reg > 64 ? 64 : window_reg);
            lead = ks > ws ? ks : ws;
            msk = nb >= 32 ? '1 : ((64'd1 << (2 * nb)) - 64'd1);
            i = sym_idx;
            seen = seen_cnt;
            back_gap = gaps[ks - 1];
            if (!g) roll = ((roll << 2) | b) & msk;
            if (seen + 1 == ks)
                push_entry(roll, 0);
            else if (seen >= ks && seen < ws)
                push_entry(roll, i - ks + 1);
            else if (seen >= lead && back_gap)
            begin
                while (fill > 0 && (i - dq_start[at(0)]) >= ws)
                begin
                    head = at(1);
                    fill--;
                end
                push_entry(roll, i - ks + 1);
                if (dq_code[at(0)] == run_min)
                begin
                    run_last = i - 1;
                    run_pos = dq_start[at(0)];
                end
                else
                begin
                    owe(run_min, run_pos, run_first, run_last, 1'b0);
                    run_min = dq_code[at(0)];
                    run_first = i - ws + 1;
                    run_last = i;
                    run_pos = dq_start[at(0)];
                end
            end
            if (seen + 1 == lead)
            begin
                run_first = 0;
                run_last = i;
                run_min = fill > 0 ? dq_code[at(0)] : 0;
                run_pos = fill > 0 ? dq_start[at(0)] : 0;
            end
            for (int j = SPAN_DEPTH - 1; j > 0; j--) gaps[j] = gaps[j - 1];
            gaps[0] = g;
            sym_idx = sym_idx + 1;
            if (seen_cnt < LEAD_LIMIT) seen_cnt++;
            if (l)
            begin
                if (seen + 1 >= lead)
                begin
                    if (fill > 0)
                    begin
                        run_min = dq_code[at(0)];
                        run_pos = dq_start[at(0)];
                    end
                    owe(run_min, run_pos, run_first, i, 1'b1);
                end
                clear_seq();
            end
        endfunction

        // accepted run word
        function void check_run(gkwm_pkg::run_rec_t got);
            gkwm_pkg::run_rec_t w;
            if (owed.size() == 0)
            begin
                $error("run word with nothing owed: code %h", got.min_code);
                errors++;
                return;
            end
            w = owed[0];
            owed.delete(0);
            if (got.min_code !== w.min_code)
            begin
                $error("min_code exp %h got %h", w.min_code, got.min_code);
                errors++;
            end
            if (got.min_position !== w.min_position)
            begin
                $error("min_position exp %0d got %0d", w.min_position, got.min_position);
                errors++;
            end
            if (got.run_start !== w.run_start)
            begin
                $error("run_start exp %0d got %0d", w.run_start, got.run_start);
                errors++;
            end
            if (got.run_end !== w.run_end)
            begin
                $error("run_end exp %0d got %0d", w.run_end, got.run_end);
                errors++;
            end
            if (got.last_run !== w.last_run)
            begin
                $error("last_run exp %0d got %0d", w.last_run, got.last_run);
                errors++;
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    logic psel, penable, pwrite;
    logic [gkwm_pkg::CFG_AW-1:0] paddr;
    logic [gkwm_pkg::CFG_DW-1:0] pwdata;
    logic [gkwm_pkg::CFG_DW-1:0] prdata;
    logic pready;

    gkwm_sym_if sym_ch ();
    gkwm_run_if run_ch ();

    gapped_kmer_window_minimizer_unit dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .sym     (sym_ch.sink),
        .run     (run_ch.source)
    );

    minimizer_scoreboard board;
    longint cycle_cnt = 0;
    bit calm_mode;   // set for a stretch with no idling on either side

    initial
    begin
        clk = 1'b0;
    end

    always #10 clk = ~clk;

    // ------------------------------------------------------------------
    // cycle counter and watchdog
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CYCLE_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // run word sink: random ready, check on every accepted word
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            run_ch.ready <= 1'b0;
        else
        begin
            if (run_ch.valid && run_ch.ready)
                board.check_run({run_ch.min_code, run_ch.min_position,
                                 run_ch.run_start, run_ch.run_end, run_ch.last_run});
            run_ch.ready <= calm_mode ? 1'b1 : ($urandom_range(99) >= 17);
        end
    end

    // ------------------------------------------------------------------
    // register write: setup cycle then access cycle
    // ------------------------------------------------------------------
    task automatic reg_write(input logic [1:0] idx, input logic [31:0] val);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= gkwm_pkg::CFG_AW'(idx) << 2;
        pwdata <= val;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (idx == gkwm_pkg::REG_KMER_BASES) board.bases_reg = val[5:0];
        else if (idx == gkwm_pkg::REG_K_SPAN) board.span_reg = val[6:0];
        else board.window_reg = val[6:0];
    endtask

    task automatic set_regs(input int nb, input int ks, input int ws);
        reg_write(gkwm_pkg::REG_KMER_BASES, nb);
        reg_write(gkwm_pkg::REG_K_SPAN, ks);
        reg_write(gkwm_pkg::REG_WINDOW_SPAN, ws);
    endtask

    // ------------------------------------------------------------------
    // symbol source: random gaps before each word, held until accepted
    // ------------------------------------------------------------------
    task automatic send_symbol(input logic [1:0] b, input logic g, input logic l);
        if (!calm_mode)
            while ($urandom_range(99) < 17)
            begin
                @(posedge clk);
                sym_ch.valid <= 1'b0;
            end
        @(posedge clk);
        sym_ch.valid <= 1'b1;
        sym_ch.base_code <= b;
        sym_ch.is_gap <= g;
        sym_ch.last_symbol <= l;
        do @(posedge clk); while (!(sym_ch.valid && sym_ch.ready));
        board.note_symbol(b, g, l);
        sym_ch.valid <= 1'b0;
    endtask

    // one sequence with random content; gap_pct sets the gap density
    task automatic send_sequence(input int len, input int gap_pct);
        for (int n = 0; n < len; n++)
            send_symbol(2'($urandom_range(3)), $urandom_range(99) < gap_pct,
                        n == len - 1);
    endtask

    // wait until all run words are in, then the block's worst symbol time
    task automatic drain();
        while (board.owed.size() != 0) @(posedge clk);
        repeat (800) @(posedge clk);
    endtask

    initial
    begin
        int sent;
        int len;
        int phase;
        board = new();
        calm_mode = 1'b0;
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        sym_ch.valid = 1'b0;
        sym_ch.base_code = '0;
        sym_ch.is_gap = 1'b0;
        sym_ch.last_symbol = 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: tiny spans so runs appear quickly
        set_regs(2, 2, 3);
        send_symbol(2'd0, 1'b0, 1'b0);
        send_symbol(2'd3, 1'b1, 1'b0);   // gap mark with base ignored
        send_symbol(2'd3, 1'b0, 1'b0);
        send_symbol(2'd1, 1'b1, 1'b0);
        send_symbol(2'd2, 1'b0, 1'b0);
        send_symbol(2'd0, 1'b1, 1'b0);
        send_symbol(2'd3, 1'b0, 1'b0);
        send_symbol(2'd1, 1'b0, 1'b1);
        // short sequence: emits nothing
        send_symbol(2'd2, 1'b0, 1'b1);
        // single-symbol sequence with spans of one
        drain();
        set_regs(0, 0, 0);               // zero acts as one
        send_symbol(2'd3, 1'b0, 1'b1);
        send_symbol(2'd1, 1'b1, 1'b0);
        send_symbol(2'd2, 1'b1, 1'b0);
        send_symbol(2'd0, 1'b0, 1'b1);
        drain();
        // out-of-range values clamp to the maxima
        set_regs(63, 127, 127);
        send_sequence(70, 50);
        drain();

        // random phases over several settings, extremes included
        sent = 0;
        phase = 0;
        while (sent < RAND_BUDGET)
        begin
            int nb, ks, ws;
            drain();
            case ($urandom_range(5))
                0: begin nb = 32; ks = 64; ws = 64; end
                1: begin nb = 1; ks = 1; ws = 1; end
                2: begin nb = 63; ks = $urandom_range(1, 6); ws = 127; end
                default:
                begin
                    nb = $urandom_range(1, 32);
                    ks = $urandom_range(1, 12);
                    ws = $urandom_range(1, 12);
                end
            endcase
            set_regs(nb, ks, ws);
            // the second phase runs with no idling at all
            calm_mode = (phase == 1);
            for (int s = 0; s < 3 && sent < RAND_BUDGET; s++)
            begin
                len = ($urandom_range(9) == 0) ? $urandom_range(1, 4)
                                                : $urandom_range(10, 140);
                if (len > RAND_BUDGET - sent)
                    len = RAND_BUDGET - sent;
                send_sequence(len, $urandom_range(10, 70));
                sent += len;
            end
            phase++;
        end
        calm_mode = 1'b0;
        drain();

        if (board.errors == 0 && board.owed.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end
endmodule

/* sim.f */
hdl/gkwm_pkg.sv
hdl/gkwm_sym_if.sv
hdl/gkwm_run_if.sv
hdl/gkwm_ram.sv
hdl/gapped_kmer_window_minimizer_unit.sv
bench/tb_gapped_kmer_window_minimizer_unit.sv
